// ===== sv/rgbf_pkg.sv =====
package rgbf_pkg;

	localparam logic [7:0] LVL_MAX = 8'd254;
	localparam logic [7:0] LVL_MIN = 8'd1;
	localparam logic [7:0] MAN_STEP = 8'd20;
	localparam logic [7:0] HOLD_LIMIT = 8'd50;
	localparam logic [7:0] CNT_MAX = 8'd255;

	localparam logic [16:0] DELAY_MAX = 17'd100000;
	localparam logic [16:0] DELAY_MIN = 17'd10000;
	localparam logic [16:0] DELAY_STEP = 17'd10000;

	localparam logic [15:0] LOAD_RESET = 16'd11362;

	// floor(p / 1000) == (p * RECIP) >> RECIP_SHIFT, exact for p < 2^24
	localparam int RECIP_SHIFT = 34;
	localparam logic [24:0] RECIP = 25'd17179870;

	localparam logic [2:0] MODE_AUTO = 3'd0;
	localparam logic [2:0] MODE_IDLE = 3'd1;
	localparam logic [2:0] MODE_RED = 3'd2;
	localparam logic [2:0] MODE_BLUE = 3'd3;
	localparam logic [2:0] MODE_GREEN = 3'd4;

	localparam logic [1:0] TRK_REL = 2'd0;
	localparam logic [1:0] TRK_FIRST = 2'd1;
	localparam logic [1:0] TRK_HELD = 2'd2;

	localparam logic [1:0] PH_BLUE_RED = 2'd0;
	localparam logic [1:0] PH_RED_GREEN = 2'd1;
	localparam logic [1:0] PH_GREEN_BLUE = 2'd2;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [2:0] mode;
		logic [16:0] delay;
	} levels_t;

	function automatic logic [7:0] lvl_up(input logic [7:0] c);
		return (c < LVL_MAX) ? c + 8'd1 : LVL_MAX;
	endfunction

	function automatic logic [7:0] lvl_down(input logic [7:0] c);
		return (c > LVL_MIN) ? c - 8'd1 : LVL_MIN;
	endfunction

	function automatic logic [7:0] jump_up(input logic [7:0] c);
		logic [8:0] s;
		s = {1'b0, c} + {1'b0, MAN_STEP};
		return (s > {1'b0, LVL_MAX}) ? LVL_MAX : s[7:0];
	endfunction

	function automatic logic [7:0] jump_down(input logic [7:0] c);
		return (c < LVL_MIN + MAN_STEP) ? LVL_MIN : c - MAN_STEP;
	endfunction

	function automatic logic [1:0] trk_next(input logic [1:0] t, input logic pressed);
		if (!pressed) begin
			return TRK_REL;
		end
		return (t == TRK_REL) ? TRK_FIRST : TRK_HELD;
	endfunction

endpackage

// ===== sv/rgbf_in_if.sv =====
interface rgbf_in_if;
	logic valid;
	logic ready;
	logic button1_pressed;
	logic button2_pressed;

	modport source (output valid, output button1_pressed, output button2_pressed, input ready);
	modport sink (input valid, input button1_pressed, input button2_pressed, output ready);
endinterface

// ===== sv/rgbf_out_if.sv =====
interface rgbf_out_if;
	logic valid;
	logic ready;
	logic [7:0] red_level;
	logic [7:0] green_level;
	logic [7:0] blue_level;
	logic [14:0] red_width;
	logic [14:0] green_width;
	logic [14:0] blue_width;
	logic [2:0] mode_now;
	logic [16:0] delay_now;

	modport source (
		output valid, output red_level, output green_level, output blue_level,
		output red_width, output green_width, output blue_width,
		output mode_now, output delay_now, input ready
	);
	modport sink (
		input valid, input red_level, input green_level, input blue_level,
		input red_width, input green_width, input blue_width,
		input mode_now, input delay_now, output ready
	);
endinterface

// ===== sv/rgbf_update.sv =====
module rgbf_update (
	input logic clk,
	input logic arst_n,
	rgbf_in_if.sink tick,
	input logic ready_s2,
	output logic valid_s1,
	output rgbf_pkg::levels_t lvl_s1
);

	logic [7:0] red_q, green_q, blue_q;
	logic [1:0] phase_q;
	logic [2:0] mode_q;
	logic [16:0] delay_q;
	logic [1:0] trk1_q, trk2_q;
	logic [7:0] sel_q, hold_q;
	logic rel_q;

	logic [7:0] red_n, green_n, blue_n;
	logic [1:0] phase_n;
	logic [2:0] mode_n;
	logic [16:0] delay_n;
	logic [1:0] trk1_n, trk2_n;
	logic [7:0] sel_n, hold_n;
	logic rel_n;
	logic take;

	assign tick.ready = !valid_s1 || ready_s2;
	assign take = tick.valid && tick.ready;

	always_comb begin
		red_n = red_q;
		green_n = green_q;
		blue_n = blue_q;
		phase_n = phase_q;
		mode_n = mode_q;
		delay_n = delay_q;
		sel_n = sel_q;
		hold_n = hold_q;
		rel_n = rel_q;

		if (mode_q == rgbf_pkg::MODE_AUTO) begin
			case (phase_q)
				rgbf_pkg::PH_RED_GREEN: begin
					if (red_q == rgbf_pkg::LVL_MIN) phase_n = rgbf_pkg::PH_GREEN_BLUE;
					red_n = rgbf_pkg::lvl_down(red_q);
					green_n = rgbf_pkg::lvl_up(green_q);
				end
				rgbf_pkg::PH_GREEN_BLUE: begin
					if (green_q == rgbf_pkg::LVL_MIN) phase_n = rgbf_pkg::PH_BLUE_RED;
					green_n = rgbf_pkg::lvl_down(green_q);
					blue_n = rgbf_pkg::lvl_up(blue_q);
				end
				default: begin
					// unused phase code fades like blue-to-red
					if (blue_q == rgbf_pkg::LVL_MIN) phase_n = rgbf_pkg::PH_RED_GREEN;
					blue_n = rgbf_pkg::lvl_down(blue_q);
					red_n = rgbf_pkg::lvl_up(red_q);
				end
			endcase
		end

		trk1_n = rgbf_pkg::trk_next(trk1_q, tick.button1_pressed);
		trk2_n = rgbf_pkg::trk_next(trk2_q, tick.button2_pressed);

		if (mode_q == rgbf_pkg::MODE_AUTO) begin
			if (trk1_n == rgbf_pkg::TRK_HELD && trk2_n == rgbf_pkg::TRK_HELD) begin
				mode_n = rgbf_pkg::MODE_IDLE;
			end else if (trk1_n == rgbf_pkg::TRK_FIRST) begin
				if (delay_q > rgbf_pkg::DELAY_MIN) delay_n = delay_q - rgbf_pkg::DELAY_STEP;
			end else if (trk2_n == rgbf_pkg::TRK_FIRST) begin
				if (delay_q < rgbf_pkg::DELAY_MAX) delay_n = delay_q + rgbf_pkg::DELAY_STEP;
			end
		end else if (trk1_n == rgbf_pkg::TRK_HELD && trk2_n == rgbf_pkg::TRK_HELD) begin
			if (hold_q > rgbf_pkg::HOLD_LIMIT) sel_n = 8'd0;
			if (rel_q) mode_n = rgbf_pkg::MODE_GREEN;
			if (hold_q < rgbf_pkg::CNT_MAX) hold_n = hold_q + 8'd1;
		end else begin
			rel_n = 1'b1;
			hold_n = 8'd0;
			if (trk1_n == rgbf_pkg::TRK_FIRST && trk2_n == rgbf_pkg::TRK_HELD) begin
				if (sel_q < rgbf_pkg::CNT_MAX) sel_n = sel_q + 8'd1;
			end else if (trk1_n == rgbf_pkg::TRK_REL && trk2_n == rgbf_pkg::TRK_REL) begin
				if (sel_q == 8'd1) mode_n = rgbf_pkg::MODE_RED;
				if (sel_q > 8'd1) mode_n = rgbf_pkg::MODE_BLUE;
				sel_n = 8'd0;
			end else if (trk1_n == rgbf_pkg::TRK_FIRST && trk2_n == rgbf_pkg::TRK_REL) begin
				case (mode_q)
					rgbf_pkg::MODE_RED: red_n = rgbf_pkg::jump_up(red_q);
					rgbf_pkg::MODE_BLUE: blue_n = rgbf_pkg::jump_up(blue_q);
					rgbf_pkg::MODE_GREEN: green_n = rgbf_pkg::jump_up(green_q);
					default: ;
				endcase
			end else if (trk2_n == rgbf_pkg::TRK_FIRST && trk1_n == rgbf_pkg::TRK_REL) begin
				case (mode_q)
					rgbf_pkg::MODE_RED: red_n = rgbf_pkg::jump_down(red_q);
					rgbf_pkg::MODE_BLUE: blue_n = rgbf_pkg::jump_down(blue_q);
					rgbf_pkg::MODE_GREEN: green_n = rgbf_pkg::jump_down(green_q);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q <= rgbf_pkg::LVL_MAX;
			green_q <= rgbf_pkg::LVL_MIN;
			blue_q <= rgbf_pkg::LVL_MIN;
			phase_q <= rgbf_pkg::PH_BLUE_RED;
			mode_q <= rgbf_pkg::MODE_AUTO;
			delay_q <= rgbf_pkg::DELAY_MAX;
			trk1_q <= rgbf_pkg::TRK_REL;
			trk2_q <= rgbf_pkg::TRK_REL;
			sel_q <= 8'd0;
			hold_q <= 8'd0;
			rel_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				red_q <= red_n;
				green_q <= green_n;
				blue_q <= blue_n;
				phase_q <= phase_n;
				mode_q <= mode_n;
				delay_q <= delay_n;
				trk1_q <= trk1_n;
				trk2_q <= trk2_n;
				sel_q <= sel_n;
				hold_q <= hold_n;
				rel_q <= rel_n;
			end
			if (tick.ready) valid_s1 <= tick.valid;
		end
	end

	// the state registers double as the first stage payload
	assign lvl_s1.red = red_q;
	assign lvl_s1.green = green_q;
	assign lvl_s1.blue = blue_q;
	assign lvl_s1.mode = mode_q;
	assign lvl_s1.delay = delay_q;

endmodule

// ===== sv/rgbf_width.sv =====
module rgbf_width (
	input logic clk,
	input logic arst_n,
	input logic valid_s1,
	input rgbf_pkg::levels_t lvl_s1,
	input logic [15:0] load,
	output logic ready_s2,
	rgbf_out_if.source result
);

	logic valid_s2;
	rgbf_pkg::levels_t lvl_s2;
	logic [23:0] prod_r_s2, prod_g_s2, prod_b_s2;
	logic ready_s3;
	logic [48:0] full_r, full_g, full_b;

	assign ready_s3 = !result.valid || result.ready;
	assign ready_s2 = !valid_s2 || ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			result.valid <= 1'b0;
		end else begin
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) result.valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			lvl_s2 <= lvl_s1;
			prod_r_s2 <= {16'd0, lvl_s1.red} * {8'd0, load};
			prod_g_s2 <= {16'd0, lvl_s1.green} * {8'd0, load};
			prod_b_s2 <= {16'd0, lvl_s1.blue} * {8'd0, load};
		end
	end

	// divide by 1000 through the reciprocal
	assign full_r = 49'(prod_r_s2) * 49'(rgbf_pkg::RECIP);
	assign full_g = 49'(prod_g_s2) * 49'(rgbf_pkg::RECIP);
	assign full_b = 49'(prod_b_s2) * 49'(rgbf_pkg::RECIP);

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			result.red_level <= lvl_s2.red;
			result.green_level <= lvl_s2.green;
			result.blue_level <= lvl_s2.blue;
			result.mode_now <= lvl_s2.mode;
			result.delay_now <= lvl_s2.delay;
			result.red_width <= full_r[rgbf_pkg::RECIP_SHIFT +: 15];
			result.green_width <= full_g[rgbf_pkg::RECIP_SHIFT +: 15];
			result.blue_width <= full_b[rgbf_pkg::RECIP_SHIFT +: 15];
		end
	end

endmodule

// ===== sv/rgb_led_fader_with_button_modes_top.sv =====
// channel  dir  beat
// tick     in   button1_pressed, button2_pressed
// result   out  red/green/blue_level, red/green/blue_width, mode_now, delay_now
// cfg      in   cfg_we, cfg_wdata -> load_q
//
// One tick accepted per cycle while the result is not stalled; its result
// reaches the result port through three register stages: state update, width
// multiply, reciprocal divide by 1000.
// Reset restores full red, auto mode, longest delay and load 11362.
// A stalled result holds the pipeline back stage by stage; tick.ready
// drops only when all three stages are full.
module rgb_led_fader_with_button_modes_top (
	input logic clk,
	input logic arst_n,
	rgbf_in_if.sink tick,
	rgbf_out_if.source result,
	input logic cfg_we,
	input logic [15:0] cfg_wdata
);

	logic [15:0] load_q;
	logic valid_s1;
	logic ready_s2;
	rgbf_pkg::levels_t lvl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= rgbf_pkg::LOAD_RESET;
		end else if (cfg_we) begin
			load_q <= cfg_wdata;
		end
	end

	rgbf_update u_update (
		.clk (clk),
		.arst_n (arst_n),
		.tick (tick),
		.ready_s2 (ready_s2),
		.valid_s1 (valid_s1),
		.lvl_s1 (lvl_s1)
	);

	rgbf_width u_width (
		.clk (clk),
		.arst_n (arst_n),
		.valid_s1 (valid_s1),
		.lvl_s1 (lvl_s1),
		.load (load_q),
		.ready_s2 (ready_s2),
		.result (result)
	);

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LAT = 3;
	localparam int CYCLE_LIMIT = 120000;
	// pacing changes with the number of accepted ticks
	localparam int PACE_SWAP = 390;
	localparam int PACE_FREE = 780;

	typedef struct packed {
		logic btn1;
		logic btn2;
	} press_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [14:0] red_w;
		logic [14:0] green_w;
		logic [14:0] blue_w;
		logic [2:0] mode;
		logic [16:0] delay;
	} led_report_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;

	rgbf_in_if tick_bus ();
	rgbf_out_if report_bus ();

	rgb_led_fader_with_button_modes_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_bus),
		.result(report_bus),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	press_t press_queue[$];
	led_report_t led_reports[$];
	press_t beat;
	led_report_t want;
	logic last_a, last_b;
	int queued, ticks_sent, reports_seen, mismatches, load_writes, manual_ticks, cycles;

	// lamp state as the block should hold it
	logic [7:0] lamp_r, lamp_g, lamp_b;
	logic [1:0] fade_ph;
	logic [2:0] lamp_mode;
	logic [16:0] step_delay;
	logic [1:0] trk_a, trk_b;
	logic [7:0] pick_cnt, both_cnt;
	logic seen_release;
	logic [15:0] period_load;

	function automatic logic [7:0] dim(input logic [7:0] c);
		return (c > rgbf_pkg::LVL_MIN) ? c - 8'd1 : rgbf_pkg::LVL_MIN;
	endfunction

	function automatic logic [7:0] lift(input logic [7:0] c);
		return (c < rgbf_pkg::LVL_MAX) ? c + 8'd1 : rgbf_pkg::LVL_MAX;
	endfunction

	function automatic logic [7:0] nudge(input logic [7:0] c, input logic up);
		if (up) begin
			return (c > rgbf_pkg::LVL_MAX - rgbf_pkg::MAN_STEP) ?
				rgbf_pkg::LVL_MAX : c + rgbf_pkg::MAN_STEP;
		end
		return (c < rgbf_pkg::LVL_MIN + rgbf_pkg::MAN_STEP) ?
			rgbf_pkg::LVL_MIN : c - rgbf_pkg::MAN_STEP;
	endfunction

	function automatic logic [14:0] pulse_width(input logic [7:0] lvl);
		int unsigned p;
		p = 32'(lvl) * 32'(period_load);
		return 15'(p / 1000);
	endfunction

	function automatic logic [1:0] trk_step(input logic [1:0] t, input logic b);
		if (!b) begin
			return rgbf_pkg::TRK_REL;
		end
		return (t == rgbf_pkg::TRK_REL) ? rgbf_pkg::TRK_FIRST : rgbf_pkg::TRK_HELD;
	endfunction

	task automatic nudge_pick(input logic up);
		case (lamp_mode)
			rgbf_pkg::MODE_RED: lamp_r = nudge(lamp_r, up);
			rgbf_pkg::MODE_BLUE: lamp_b = nudge(lamp_b, up);
			rgbf_pkg::MODE_GREEN: lamp_g = nudge(lamp_g, up);
			default: ;
		endcase
	endtask

	task automatic apply_tick(input logic b1, input logic b2);
		led_report_t rep;
		if (lamp_mode == rgbf_pkg::MODE_AUTO) begin
			case (fade_ph)
				rgbf_pkg::PH_RED_GREEN: begin
					if (lamp_r == rgbf_pkg::LVL_MIN) fade_ph = rgbf_pkg::PH_GREEN_BLUE;
					lamp_r = dim(lamp_r);
					lamp_g = lift(lamp_g);
				end
				rgbf_pkg::PH_GREEN_BLUE: begin
					if (lamp_g == rgbf_pkg::LVL_MIN) fade_ph = rgbf_pkg::PH_BLUE_RED;
					lamp_g = dim(lamp_g);
					lamp_b = lift(lamp_b);
				end
				default: begin
					if (lamp_b == rgbf_pkg::LVL_MIN) fade_ph = rgbf_pkg::PH_RED_GREEN;
					lamp_b = dim(lamp_b);
					lamp_r = lift(lamp_r);
				end
			endcase
		end
		trk_a = trk_step(trk_a, b1);
		trk_b = trk_step(trk_b, b2);
		if (lamp_mode == rgbf_pkg::MODE_AUTO) begin
			if (trk_a == rgbf_pkg::TRK_HELD && trk_b == rgbf_pkg::TRK_HELD) begin
				lamp_mode = rgbf_pkg::MODE_IDLE;
			end else if (trk_a == rgbf_pkg::TRK_FIRST) begin
				if (step_delay > rgbf_pkg::DELAY_MIN) step_delay -= rgbf_pkg::DELAY_STEP;
			end else if (trk_b == rgbf_pkg::TRK_FIRST) begin
				if (step_delay < rgbf_pkg::DELAY_MAX) step_delay += rgbf_pkg::DELAY_STEP;
			end
		end else if (trk_a == rgbf_pkg::TRK_HELD && trk_b == rgbf_pkg::TRK_HELD) begin
			if (both_cnt > rgbf_pkg::HOLD_LIMIT) pick_cnt = '0;
			if (seen_release) lamp_mode = rgbf_pkg::MODE_GREEN;
			if (both_cnt < rgbf_pkg::CNT_MAX) both_cnt++;
		end else begin
			seen_release = 1'b1;
			both_cnt = '0;
			if (trk_a == rgbf_pkg::TRK_FIRST && trk_b == rgbf_pkg::TRK_HELD) begin
				if (pick_cnt < rgbf_pkg::CNT_MAX) pick_cnt++;
			end else if (trk_a == rgbf_pkg::TRK_REL && trk_b == rgbf_pkg::TRK_REL) begin
				if (pick_cnt == 8'd1) lamp_mode = rgbf_pkg::MODE_RED;
				if (pick_cnt > 8'd1) lamp_mode = rgbf_pkg::MODE_BLUE;
				pick_cnt = '0;
			end else if (trk_a == rgbf_pkg::TRK_FIRST && trk_b == rgbf_pkg::TRK_REL) begin
				nudge_pick(1'b1);
			end else if (trk_b == rgbf_pkg::TRK_FIRST && trk_a == rgbf_pkg::TRK_REL) begin
				nudge_pick(1'b0);
			end
		end
		if (lamp_mode != rgbf_pkg::MODE_AUTO) manual_ticks++;
		rep.red = lamp_r;
		rep.green = lamp_g;
		rep.blue = lamp_b;
		rep.red_w = pulse_width(lamp_r);
		rep.green_w = pulse_width(lamp_g);
		rep.blue_w = pulse_width(lamp_b);
		rep.mode = lamp_mode;
		rep.delay = step_delay;
		led_reports.push_back(rep);
	endtask

	function automatic void check_field(string what, int unsigned exp_v, int unsigned got_v);
		if (exp_v != got_v) begin
			mismatches++;
			$display("%0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
		end
	endfunction

	function automatic int send_gap_pct();
		if (ticks_sent < PACE_SWAP) return 22;
		if (ticks_sent < PACE_FREE) return 60;
		return 0;
	endfunction

	function automatic int recv_gap_pct();
		if (ticks_sent < PACE_SWAP) return 60;
		if (ticks_sent < PACE_FREE) return 22;
		return 0;
	endfunction

	// tick driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_bus.valid && tick_bus.ready) begin
				apply_tick(tick_bus.button1_pressed, tick_bus.button2_pressed);
				ticks_sent++;
			end
			if (!tick_bus.valid || tick_bus.ready) begin
				if (press_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct()) begin
					beat = press_queue.pop_front();
					tick_bus.valid <= 1'b1;
					tick_bus.button1_pressed <= beat.btn1;
					tick_bus.button2_pressed <= beat.btn2;
				end else begin
					tick_bus.valid <= 1'b0;
				end
			end
		end
	end

	// report monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (report_bus.valid && report_bus.ready) begin
				reports_seen++;
				if (led_reports.size() == 0) begin
					mismatches++;
					$display("%0t: report beat with nothing expected (red %0d mode %0d)",
						$time, report_bus.red_level, report_bus.mode_now);
				end else begin
					want = led_reports.pop_front();
					check_field("red_level", 32'(want.red), 32'(report_bus.red_level));
					check_field("green_level", 32'(want.green), 32'(report_bus.green_level));
					check_field("blue_level", 32'(want.blue), 32'(report_bus.blue_level));
					check_field("red_width", 32'(want.red_w), 32'(report_bus.red_width));
					check_field("green_width", 32'(want.green_w),
						32'(report_bus.green_width));
					check_field("blue_width", 32'(want.blue_w), 32'(report_bus.blue_width));
					check_field("mode_now", 32'(want.mode), 32'(report_bus.mode_now));
					check_field("delay_now", 32'(want.delay), 32'(report_bus.delay_now));
				end
			end
			report_bus.ready <= ($urandom_range(0, 99) >= recv_gap_pct());
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reports still owed", cycles,
				led_reports.size());
			$display("** rgb_led_fader_with_button_modes_top: FAILED **");
			$finish;
		end
	end

	task automatic queue_tick(input logic a, input logic b);
		press_t p;
		p.btn1 = a;
		p.btn2 = b;
		press_queue.push_back(p);
		last_a = a;
		last_b = b;
		queued++;
	endtask

	task automatic queue_repeat(input logic a, input logic b, input int n);
		repeat (n) queue_tick(a, b);
	endtask

	// button 2 held, button 1 tapped k times; no release at the end
	task automatic queue_presses(input int k);
		queue_tick(1'b0, 1'b1);
		repeat (k) begin
			queue_tick(1'b1, 1'b1);
			queue_tick(1'b0, 1'b1);
		end
	endtask

	// random auto-mode traffic that never holds both buttons two ticks running
	task automatic queue_auto(input int n, input int p1, input int p2);
		logic a, b;
		repeat (n) begin
			a = ($urandom_range(0, 99) < p1);
			b = ($urandom_range(0, 99) < p2);
			if (a && b && last_a && last_b) begin
				if ($urandom_range(0, 1)) a = 1'b0;
				else b = 1'b0;
			end
			queue_tick(a, b);
		end
	endtask

	task automatic settle();
		@(negedge clk);
		while (press_queue.size() != 0 || tick_bus.valid || led_reports.size() != 0) begin
			@(negedge clk);
		end
		repeat (LAT + 4) @(negedge clk);
	endtask

	task automatic set_load(input logic [15:0] v);
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		period_load = v;
		load_writes++;
		@(negedge clk);
	endtask

	initial begin
		int mark, n;
		tick_bus.valid = 1'b0;
		tick_bus.button1_pressed = 1'b0;
		tick_bus.button2_pressed = 1'b0;
		report_bus.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		last_a = 1'b0;
		last_b = 1'b0;
		queued = 0;
		ticks_sent = 0;
		reports_seen = 0;
		mismatches = 0;
		load_writes = 0;
		manual_ticks = 0;
		cycles = 0;
		lamp_r = rgbf_pkg::LVL_MAX;
		lamp_g = rgbf_pkg::LVL_MIN;
		lamp_b = rgbf_pkg::LVL_MIN;
		fade_ph = rgbf_pkg::PH_BLUE_RED;
		lamp_mode = rgbf_pkg::MODE_AUTO;
		step_delay = rgbf_pkg::DELAY_MAX;
		trk_a = rgbf_pkg::TRK_REL;
		trk_b = rgbf_pkg::TRK_REL;
		pick_cnt = '0;
		both_cnt = '0;
		seen_release = 1'b0;
		period_load = rgbf_pkg::LOAD_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// auto mode with the reset load: delay steps, clamp at the top,
		// button 1 wins when both are fresh
		queue_tick(1'b0, 1'b0);
		queue_repeat(1'b1, 1'b0, 2);
		queue_repeat(1'b0, 1'b1, 2);
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b0, 1'b1);
		queue_tick(1'b1, 1'b1);
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b1, 1'b1);
		queue_tick(1'b0, 1'b0);

		// fade through all three phases and back to the first;
		// delay driven to both ends
		set_load(16'hFFFF);
		queue_auto(180, 45, 10);
		queue_auto(180, 10, 45);
		set_load(16'h0000);
		queue_auto(150, 25, 25);

		// into manual mode, then each selection and adjustment once
		set_load(16'($urandom_range(1, 65534)));
		queue_tick(1'b0, 1'b0);
		queue_repeat(1'b1, 1'b1, 3);
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b1, 1'b0);
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b0, 1'b1);
		queue_tick(1'b0, 1'b0);
		queue_presses(1);
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b1, 1'b0);
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b0, 1'b1);
		queue_tick(1'b0, 1'b0);
		queue_presses(2);
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b0, 1'b1);
		queue_tick(1'b0, 1'b0);
		queue_repeat(1'b1, 1'b1, 2);
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b1, 1'b0);
		queue_tick(1'b0, 1'b0);

		// select counter saturation, and a long hold wiping a pending selection
		set_load(16'd1000);
		queue_presses(256);
		queue_tick(1'b0, 1'b0);
		queue_presses(3);
		queue_repeat(1'b1, 1'b1, 60);
		queue_tick(1'b0, 1'b0);

		// random manual sequences with some noise
		set_load(16'($urandom_range(0, 65535)));
		mark = queued;
		while (queued - mark < 30) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					queue_presses($urandom_range(1, 4));
					queue_tick(1'b0, 1'b0);
				end
				3, 4, 5, 6: begin
					n = $urandom_range(1, 14);
					repeat (n) begin
						if ($urandom_range(0, 1)) queue_tick(1'b1, 1'b0);
						else queue_tick(1'b0, 1'b1);
						queue_tick(1'b0, 1'b0);
					end
				end
				7, 8: begin
					queue_repeat(1'b1, 1'b1, $urandom_range(2, 70));
					queue_tick(1'b0, 1'b0);
				end
				default: begin
					n = $urandom_range(1, 6);
					repeat (n) queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			endcase
		end
		settle();

		$display("run: %0d ticks, %0d reports checked, %0d of them in manual mode",
			ticks_sent, reports_seen, manual_ticks);
		$display("run: %0d load writes, %0d mismatches", load_writes, mismatches);
		if (mismatches == 0) begin
			$display("** rgb_led_fader_with_button_modes_top: PASSED **");
		end else begin
			$display("** rgb_led_fader_with_button_modes_top: FAILED **");
		end
		$finish;
	end

endmodule

// ===== rgb_led_fader_with_button_modes_top.f =====
sv/rgbf_pkg.sv
sv/rgbf_in_if.sv
sv/rgbf_out_if.sv
sv/rgbf_update.sv
sv/rgbf_width.sv
sv/rgb_led_fader_with_button_modes_top.sv
tb/tb_top.sv
